// ===== rtl/cst_pkg.sv =====
package cst_pkg;

    // Default sizing
    localparam int DEF_NUM_SEMS     = 20;
    localparam int DEF_RING_SLOTS   = 10;
    localparam int DEF_TASK_ID_BITS = 6;

    // Fixed field widths
    localparam int TAG_W      = 32;
    localparam int INIT_W     = 15;
    localparam int SEM_IDX_W  = 5;
    localparam int TASK_W     = 6;
    localparam int SLOT_W     = 5;
    localparam int COUNT_W    = 16;

    // Count saturation limits, two's complement
    localparam logic [COUNT_W-1:0] COUNT_MIN = 16'h8000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'h7FFF;

    localparam logic STS_OK   = 1'b0;
    localparam logic STS_FAIL = 1'b1;

    typedef enum logic [1:0] {
        ACT_OPEN   = 2'd0,
        ACT_WAIT   = 2'd1,
        ACT_POST   = 2'd2,
        ACT_UNLINK = 2'd3
    } t_action;

    typedef struct packed {
        t_action                action;
        logic [TAG_W-1:0]       name_tag;
        logic [INIT_W-1:0]      initial_count;
        logic [SEM_IDX_W-1:0]   sem_index;
        logic [TASK_W-1:0]      task_id;
    } t_request;

    typedef struct packed {
        logic                   status;
        logic [SLOT_W-1:0]      slot_index;
        logic                   must_block;
        logic                   wake_valid;
        logic [TASK_W-1:0]      wake_task;
    } t_result;

    // Per-slot header; count is two's complement
    typedef struct packed {
        logic                   used;
        logic [COUNT_W-1:0]     count;
        logic [TAG_W-1:0]       tag;
    } t_slot_hdr;

    typedef struct packed {
        logic                   rd;
        logic                   wr;
        logic                   clr;
    } t_slot_cmd;

endpackage

// ===== rtl/cst_slot_store.sv =====
module cst_slot_store
    import cst_pkg::*;
#(
    parameter int NUM_SEMS   = DEF_NUM_SEMS,
    parameter int RING_SLOTS = DEF_RING_SLOTS,
    localparam int IDX_W     = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1,
    localparam int RP_W      = $clog2(RING_SLOTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_slot_cmd         i_cmd,
    input  logic [IDX_W-1:0]  i_rd_addr,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  t_slot_hdr         i_wr_hdr,
    input  logic [RP_W-1:0]   i_wr_head,
    input  logic [RP_W-1:0]   i_wr_tail,
    output t_slot_hdr         o_rd_hdr,
    output logic [RP_W-1:0]   o_rd_head,
    output logic [RP_W-1:0]   o_rd_tail
);

    t_slot_hdr           r_mem_hdr [NUM_SEMS];
    logic [2*RP_W-1:0]   r_mem_ptr [NUM_SEMS];
    logic [NUM_SEMS-1:0] r_vld;

    t_slot_hdr           r_rd_hdr;
    logic [2*RP_W-1:0]   r_rd_ptr;
    logic                r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem_hdr[i_wr_addr] <= i_wr_hdr;
            r_mem_ptr[i_wr_addr] <= {i_wr_head, i_wr_tail};
        end
        if (i_cmd.rd) begin
            r_rd_hdr <= r_mem_hdr[i_rd_addr];
            r_rd_ptr <= r_mem_ptr[i_rd_addr];
        end
    end

    // Entry valid bits: an invalid entry reads as the reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                r_vld[i_wr_addr] <= 1'b1;
            end else if (i_cmd.clr) begin
                r_vld[i_wr_addr] <= 1'b0;
            end
            if (i_cmd.rd) begin
                r_rd_ok <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_hdr  = r_rd_ok ? r_rd_hdr : '0;
    assign o_rd_head = r_rd_ok ? r_rd_ptr[2*RP_W-1:RP_W] : '0;
    assign o_rd_tail = r_rd_ok ? r_rd_ptr[RP_W-1:0] : RP_W'(RING_SLOTS - 1);

endmodule

// ===== rtl/counting_semaphore_table.sv =====
// Counting semaphore table with a FIFO wait ring per semaphore.
//
// Request channel: a request on i_req is taken at a rising edge with start
// high and busy low. busy stays high while the request is worked on.
// Result channel: exactly one result per request, shown on o_result for one
// cycle with o_done high. The receiver cannot stall; o_done is a strobe.
// The next request may be taken in the same cycle that o_done is high.
//
// Steps from accept to o_done:
//   wait, post with index past table: range check only
//   wait, post without wake-up: slot read, update
//   post with wake-up: slot read, update, extra ring memory read
//   open, unlink: slot scan, one slot per cycle through the shared
//                 tag comparator; a tag match ends the scan early.
// Slot headers sit in a memory with one read and one write port; the scan
// rate is set by that single read port.
// Reset: synchronous, active low. Slot valid bits are cleared at once, so
// all slots read as unused, count 0, tag 0, empty ring; no clearing pass.
module counting_semaphore_table
    import cst_pkg::*;
#(
    parameter int NUM_SEMS     = DEF_NUM_SEMS,
    parameter int RING_SLOTS   = DEF_RING_SLOTS,
    parameter int TASK_ID_BITS = DEF_TASK_ID_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_request i_req,
    output logic     busy,
    output logic     o_done,
    output t_result  o_result
);

    localparam int IDX_W      = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int SC_W       = $clog2(NUM_SEMS + 1);
    localparam int RP_W       = $clog2(RING_SLOTS);
    localparam int RING_DEPTH = NUM_SEMS * RING_SLOTS;
    localparam int RA_W       = $clog2(RING_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOT_RD,
        S_SCAN,
        S_EXEC,
        S_POP
    } t_state;

    t_state              r_state, n_state;
    t_request            r_req, n_req;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [SC_W-1:0]     r_iss_idx, n_iss_idx;
    logic                r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]    r_chk_idx, n_chk_idx;
    logic                r_free_found, n_free_found;
    logic [IDX_W-1:0]    r_free_idx, n_free_idx;
    logic                r_done, n_done;
    t_result             r_out, n_out;

    t_slot_cmd           slot_cmd;
    logic [IDX_W-1:0]    slot_rd_addr;
    logic [IDX_W-1:0]    slot_wr_addr;
    t_slot_hdr           slot_wr_hdr;
    logic [RP_W-1:0]     slot_wr_head;
    logic [RP_W-1:0]     slot_wr_tail;
    t_slot_hdr           slot_rd_hdr;
    logic [RP_W-1:0]     slot_rd_head;
    logic [RP_W-1:0]     slot_rd_tail;

    logic [TASK_ID_BITS-1:0] r_ring_mem [RING_DEPTH];
    logic [TASK_ID_BITS-1:0] r_ring_q;
    logic                    ring_wr;
    logic                    ring_rd;
    logic [RA_W-1:0]         ring_wr_addr;
    logic [RA_W-1:0]         ring_rd_addr;
    logic [TASK_ID_BITS-1:0] ring_wr_data;

    function automatic logic [RP_W-1:0] f_ring_next(input logic [RP_W-1:0] p);
        f_ring_next = (p == RP_W'(RING_SLOTS - 1)) ? '0 : p + RP_W'(1);
    endfunction

    function automatic logic [RA_W-1:0] f_ring_addr(input logic [IDX_W-1:0] s,
                                                    input logic [RP_W-1:0]  p);
        f_ring_addr = RA_W'(s) * RA_W'(RING_SLOTS) + RA_W'(p);
    endfunction

    cst_slot_store #(
        .NUM_SEMS   (NUM_SEMS),
        .RING_SLOTS (RING_SLOTS)
    ) u_slot_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (slot_cmd),
        .i_rd_addr  (slot_rd_addr),
        .i_wr_addr  (slot_wr_addr),
        .i_wr_hdr   (slot_wr_hdr),
        .i_wr_head  (slot_wr_head),
        .i_wr_tail  (slot_wr_tail),
        .o_rd_hdr   (slot_rd_hdr),
        .o_rd_head  (slot_rd_head),
        .o_rd_tail  (slot_rd_tail)
    );

    // Task ring storage, one row of RING_SLOTS entries per semaphore
    always_ff @(posedge i_clk) begin
        if (ring_wr) begin
            r_ring_mem[ring_wr_addr] <= ring_wr_data;
        end
        if (ring_rd) begin
            r_ring_q <= r_ring_mem[ring_rd_addr];
        end
    end

    always_comb begin
        logic               v_idx_ok;
        logic [IDX_W-1:0]   v_req_idx;
        logic               v_is_wait;
        logic [COUNT_W-1:0] v_sum;
        logic               v_sat;
        logic [COUNT_W-1:0] v_cnt;
        logic [RP_W-1:0]    v_tail_n;
        logic [RP_W-1:0]    v_tail_nn;

        n_state      = r_state;
        n_req        = r_req;
        n_idx        = r_idx;
        n_iss_idx    = r_iss_idx;
        n_chk_vld    = r_chk_vld;
        n_chk_idx    = r_chk_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_done       = 1'b0;
        n_out        = r_out;

        slot_cmd     = '0;
        slot_rd_addr = '0;
        slot_wr_addr = r_idx;
        slot_wr_hdr  = slot_rd_hdr;
        slot_wr_head = slot_rd_head;
        slot_wr_tail = slot_rd_tail;

        ring_wr      = 1'b0;
        ring_rd      = 1'b0;
        ring_wr_addr = '0;
        ring_rd_addr = '0;
        ring_wr_data = TASK_ID_BITS'(r_req.task_id);

        v_idx_ok  = (32'(r_req.sem_index) < 32'(NUM_SEMS));
        v_req_idx = IDX_W'(r_req.sem_index);
        v_is_wait = (r_req.action == ACT_WAIT);

        // Shared count adder with saturation
        v_sum = slot_rd_hdr.count + (v_is_wait ? {COUNT_W{1'b1}} : COUNT_W'(1));
        v_sat = v_is_wait ? (slot_rd_hdr.count == COUNT_MIN)
                          : (slot_rd_hdr.count == COUNT_MAX);
        v_cnt = v_sat ? slot_rd_hdr.count : v_sum;

        v_tail_n  = f_ring_next(slot_rd_tail);
        v_tail_nn = f_ring_next(v_tail_n);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req        = i_req;
                    n_iss_idx    = '0;
                    n_chk_vld    = 1'b0;
                    n_free_found = 1'b0;
                    if (i_req.action == ACT_OPEN || i_req.action == ACT_UNLINK) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_SLOT_RD;
                    end
                end
            end

            S_SLOT_RD: begin
                if (v_idx_ok) begin
                    slot_cmd.rd  = 1'b1;
                    slot_rd_addr = v_req_idx;
                    n_idx        = v_req_idx;
                    n_state      = S_EXEC;
                end else begin
                    n_out        = '0;
                    n_out.status = STS_FAIL;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            // Issue one slot read per cycle; compare the previous read's tag
            S_SCAN: begin
                if (r_iss_idx < SC_W'(NUM_SEMS)) begin
                    slot_cmd.rd  = 1'b1;
                    slot_rd_addr = r_iss_idx[IDX_W-1:0];
                    n_chk_vld    = 1'b1;
                    n_chk_idx    = r_iss_idx[IDX_W-1:0];
                    n_iss_idx    = r_iss_idx + SC_W'(1);
                end else begin
                    n_chk_vld    = 1'b0;
                end

                if (r_chk_vld) begin
                    if (slot_rd_hdr.tag == r_req.name_tag) begin
                        n_out            = '0;
                        n_out.status     = STS_OK;
                        n_out.slot_index = SLOT_W'(r_chk_idx);
                        n_done           = 1'b1;
                        n_state          = S_IDLE;
                        if (r_req.action == ACT_UNLINK) begin
                            slot_cmd.clr = 1'b1;
                            slot_wr_addr = r_chk_idx;
                        end
                    end else if (!slot_rd_hdr.used && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_chk_idx;
                    end
                end else if (r_iss_idx == SC_W'(NUM_SEMS)) begin
                    // Scan over, no tag match
                    n_out   = '0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_req.action == ACT_OPEN && r_free_found) begin
                        slot_cmd.wr        = 1'b1;
                        slot_wr_addr       = r_free_idx;
                        slot_wr_hdr.used   = 1'b1;
                        slot_wr_hdr.count  = COUNT_W'(r_req.initial_count);
                        slot_wr_hdr.tag    = r_req.name_tag;
                        slot_wr_head       = '0;
                        slot_wr_tail       = RP_W'(RING_SLOTS - 1);
                        n_out.status       = STS_OK;
                        n_out.slot_index   = SLOT_W'(r_free_idx);
                    end else begin
                        n_out.status       = STS_FAIL;
                    end
                end
            end

            S_EXEC: begin
                slot_cmd.wr       = 1'b1;
                slot_wr_addr      = r_idx;
                slot_wr_hdr.count = v_cnt;
                n_out             = '0;
                n_out.status      = STS_OK;
                n_out.slot_index  = SLOT_W'(r_idx);
                if (v_is_wait) begin
                    if (v_cnt[COUNT_W-1]) begin
                        n_out.must_block = 1'b1;
                        // full ring: task dropped, count still moves
                        if (v_tail_nn != slot_rd_head) begin
                            slot_wr_tail = v_tail_n;
                            ring_wr      = 1'b1;
                            ring_wr_addr = f_ring_addr(r_idx, v_tail_n);
                        end
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if ((v_cnt[COUNT_W-1] || v_cnt == '0)
                             && v_tail_n != slot_rd_head) begin
                    slot_wr_head = f_ring_next(slot_rd_head);
                    ring_rd      = 1'b1;
                    ring_rd_addr = f_ring_addr(r_idx, slot_rd_head);
                    n_state      = S_POP;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_POP: begin
                n_out.wake_valid = 1'b1;
                n_out.wake_task  = TASK_W'(r_ring_q);
                n_done           = 1'b1;
                n_state          = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_chk_idx  <= n_chk_idx;
        r_free_idx <= n_free_idx;
        r_out      <= n_out;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_iss_idx    <= '0;
            r_chk_vld    <= 1'b0;
            r_free_found <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_iss_idx    <= n_iss_idx;
            r_chk_vld    <= n_chk_vld;
            r_free_found <= n_free_found;
            r_done       <= n_done;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

    // A result only follows a cycle of work
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without preceding work");

    // An accepted request always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start");

    // Wake-up only reported for a post
    a_wake_on_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.wake_valid) |-> (r_req.action == ACT_POST))
        else $error("wake-up reported for a non-post request");

    // Block only reported for a wait
    a_block_on_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.must_block) |-> (r_req.action == ACT_WAIT))
        else $error("block reported for a non-wait request");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    import cst_pkg::*;

    localparam int NUM_SEMS     = DEF_NUM_SEMS;
    localparam int RING_SLOTS   = DEF_RING_SLOTS;
    localparam int INIT_MAX     = 2**INIT_W - 1;
    localparam int IDX_MAX      = 2**SEM_IDX_W - 1;
    localparam int TAG_POOL     = 24;      // a few more tags than slots, so the table fills
    localparam int MAX_GAP      = 40;
    localparam int DRAIN_CYCLES = DEF_NUM_SEMS + 12;   // longest open/unlink scan plus margin
    localparam int RANDOM_ITEMS = 420;                 // per idle phase

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_request i_req   = '0;
    logic     busy;
    logic     o_done;
    t_result  o_result;

    counting_semaphore_table i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Semaphore table predictor: own copy of every slot and its wait ring.
    // Counts are 16-bit two's complement, as in the block.
    // ------------------------------------------------------------------
    logic               sem_used  [NUM_SEMS];
    logic [COUNT_W-1:0] sem_count [NUM_SEMS];
    logic [TAG_W-1:0]   sem_tag   [NUM_SEMS];
    int                 ring_head [NUM_SEMS];
    int                 ring_tail [NUM_SEMS];
    logic [TASK_W-1:0]  ring_slot [NUM_SEMS][RING_SLOTS];

    t_result            pending_results[$];    // one per accepted request, in order
    int                 fail_count = 0;
    int                 idle_pct   = 0;        // chance, in percent, that the sender idles a cycle
    logic [TAG_W-1:0]   tag_pool [TAG_POOL];

    function automatic int ring_step(int p);
        return (p + 1) % RING_SLOTS;
    endfunction

    // Empty ring: head sits one step after tail.
    function automatic void empty_ring(int s);
        ring_head[s] = 0;
        ring_tail[s] = RING_SLOTS - 1;
    endfunction

    function automatic void reset_table();
        for (int s = 0; s < NUM_SEMS; s++) begin
            sem_used[s]  = 1'b0;
            sem_count[s] = '0;
            sem_tag[s]   = '0;
            empty_ring(s);
        end
    endfunction

    // Applies one request to the predicted table and returns the result it gives.
    function automatic t_result apply_request(t_request req);
        t_result res;
        int      idx;
        res        = '0;
        res.status = STS_FAIL;
        idx        = req.sem_index;
        case (req.action)
            ACT_OPEN: begin
                // tag match first, used or not; tag 0 matches any unnamed slot
                for (int s = 0; s < NUM_SEMS && res.status == STS_FAIL; s++) begin
                    if (sem_tag[s] == req.name_tag) begin
                        res.status     = STS_OK;
                        res.slot_index = SLOT_W'(s);
                    end
                end
                for (int s = 0; s < NUM_SEMS && res.status == STS_FAIL; s++) begin
                    if (!sem_used[s]) begin
                        sem_used[s]    = 1'b1;
                        sem_tag[s]     = req.name_tag;
                        sem_count[s]   = COUNT_W'(req.initial_count);
                        empty_ring(s);
                        res.status     = STS_OK;
                        res.slot_index = SLOT_W'(s);
                    end
                end
            end
            ACT_UNLINK: begin
                for (int s = 0; s < NUM_SEMS && res.status == STS_FAIL; s++) begin
                    if (sem_tag[s] == req.name_tag) begin
                        sem_used[s]    = 1'b0;
                        sem_count[s]   = '0;
                        sem_tag[s]     = '0;
                        empty_ring(s);
                        res.status     = STS_OK;
                        res.slot_index = SLOT_W'(s);
                    end
                end
            end
            default: begin
                // wait and post; an index past the table changes nothing
                if (idx < NUM_SEMS) begin
                    res.status     = STS_OK;
                    res.slot_index = SLOT_W'(idx);
                    if (req.action == ACT_WAIT) begin
                        if (sem_count[idx] != COUNT_MIN)
                            sem_count[idx] = sem_count[idx] - 1'b1;
                        if (sem_count[idx][COUNT_W-1]) begin
                            res.must_block = 1'b1;
                            // full ring holds RING_SLOTS-1 tasks; the waiter is dropped
                            if (ring_step(ring_step(ring_tail[idx])) != ring_head[idx]) begin
                                ring_tail[idx] = ring_step(ring_tail[idx]);
                                ring_slot[idx][ring_tail[idx]] = req.task_id;
                            end
                        end
                    end else begin
                        if (sem_count[idx] != COUNT_MAX)
                            sem_count[idx] = sem_count[idx] + 1'b1;
                        if ((sem_count[idx][COUNT_W-1] || sem_count[idx] == '0) &&
                            ring_step(ring_tail[idx]) != ring_head[idx]) begin
                            res.wake_valid = 1'b1;
                            res.wake_task  = ring_slot[idx][ring_head[idx]];
                            ring_head[idx] = ring_step(ring_head[idx]);
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_request make_req(t_action act, logic [TAG_W-1:0] tag,
                                          logic [INIT_W-1:0] init, logic [SEM_IDX_W-1:0] idx,
                                          logic [TASK_W-1:0] tid);
        t_request r;
        r.action        = act;
        r.name_tag      = tag;
        r.initial_count = init;
        r.sem_index     = idx;
        r.task_id       = tid;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Inputs change on the falling edge; the request is
    // taken at the rising edge where start is high and busy is low. start
    // stays high across back-to-back requests.
    // ------------------------------------------------------------------
    task automatic send_request(input t_request req);
        int          gap = 0;
        logic [63:0] noise;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            noise = {$urandom(), $urandom()};
            @(negedge i_clk);
            start <= 1'b0;
            i_req <= noise[$bits(t_request)-1:0];   // junk while idle
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_request(req));
    endtask

    // ------------------------------------------------------------------
    // Result checker: every o_done strobe is matched with the oldest
    // pending result, field by field.
    // ------------------------------------------------------------------
    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: %p", o_result);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status",     want.status,     o_result.status);
                check_field("slot_index", want.slot_index, o_result.slot_index);
                check_field("must_block", want.must_block, o_result.must_block);
                check_field("wake_valid", want.wake_valid, o_result.wake_valid);
                check_field("wake_task",  want.wake_task,  o_result.wake_task);
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Open by tag: tag 0 matches the unnamed slot 0 without claiming it,
    // new tags claim the first unused slot, a known tag returns its slot.
    // Unlink with an unknown tag fails.
    task automatic test_open_unlink();
        send_request(make_req(ACT_OPEN,   32'h0000_0000, 15'd5,    5'd0, 6'd0));
        send_request(make_req(ACT_OPEN,   32'hFFFF_FFFF, INIT_MAX, 5'd0, 6'd0));
        send_request(make_req(ACT_OPEN,   32'h0000_0001, 15'd0,    5'd0, 6'd0));
        send_request(make_req(ACT_OPEN,   32'hFFFF_FFFF, 15'd0,    5'd0, 6'd0));
        send_request(make_req(ACT_UNLINK, 32'hDEAD_BEEF, 15'd0,    5'd0, 6'd0));
        send_request(make_req(ACT_UNLINK, 32'h0000_0001, 15'd0,    5'd0, 6'd0));
    endtask

    // Slot 0 starts at the largest count: post saturates, wait steps down.
    task automatic test_count_ceiling();
        send_request(make_req(ACT_POST,   32'h0,         15'd0, 5'd0, 6'd0));
        send_request(make_req(ACT_WAIT,   32'h0,         15'd0, 5'd0, 6'h3F));
        send_request(make_req(ACT_UNLINK, 32'hFFFF_FFFF, 15'd0, 5'd0, 6'd0));
    endtask

    // Indexes past the table fail; an unused slot still counts and queues.
    task automatic test_index_range();
        send_request(make_req(ACT_WAIT, 32'h0, 15'd0, 5'(NUM_SEMS), 6'd1));
        send_request(make_req(ACT_POST, 32'h0, 15'd0, 5'(IDX_MAX),  6'd2));
        send_request(make_req(ACT_WAIT, 32'h0, 15'd0, 5'd5,         6'h15));
        send_request(make_req(ACT_POST, 32'h0, 15'd0, 5'd5,         6'h2A));
    endtask

    // As many waiters as the ring holds: none is dropped, so every post
    // wakes one, in order, and the last post brings the count back to zero.
    task automatic test_wait_ring();
        send_request(make_req(ACT_OPEN, 32'h5A5A_5A5A, 15'd0, 5'd0, 6'd0));
        for (int k = 0; k < RING_SLOTS - 1; k++)
            send_request(make_req(ACT_WAIT, 32'h0, 15'd0, 5'd0, 6'(k * 7 + 3)));
        for (int k = 0; k < RING_SLOTS - 1; k++)
            send_request(make_req(ACT_POST, 32'h0, 15'd0, 5'd0, 6'd0));
        send_request(make_req(ACT_UNLINK, 32'h5A5A_5A5A, 15'd0, 5'd0, 6'd0));
    endtask

    // ------------------------------------------------------------------
    // Random traffic: tags mostly from a small pool so opens hit, claim
    // and fill the table; waits and posts mostly on a few hot slots with
    // small counts so rings fill and drain. Some noise: fresh random tags,
    // large counts and indexes past the table.
    // ------------------------------------------------------------------
    task automatic test_random(input int n_items);
        t_request    r;
        int unsigned pick;
        for (int k = 0; k < n_items; k++) begin
            r.name_tag = ($urandom_range(9) < 8) ? tag_pool[$urandom_range(TAG_POOL - 1)]
                                                 : TAG_W'($urandom());
            pick = $urandom_range(99);
            if (pick < 70)
                r.initial_count = INIT_W'($urandom_range(3));
            else if (pick < 92)
                r.initial_count = INIT_W'($urandom());
            else
                r.initial_count = INIT_W'(INIT_MAX);
            pick = $urandom_range(99);
            if (pick < 55)
                r.sem_index = SEM_IDX_W'($urandom_range(3));
            else if (pick < 92)
                r.sem_index = SEM_IDX_W'($urandom_range(NUM_SEMS - 1));
            else
                r.sem_index = SEM_IDX_W'($urandom_range(IDX_MAX, NUM_SEMS));
            r.task_id = TASK_W'($urandom());
            pick = $urandom_range(99);
            if (pick < 20)
                r.action = ACT_OPEN;
            else if (pick < 56)
                r.action = ACT_WAIT;
            else if (pick < 88)
                r.action = ACT_POST;
            else
                r.action = ACT_UNLINK;
            send_request(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_table();
        tag_pool[0] = '0;
        for (int k = 1; k < TAG_POOL; k++)
            tag_pool[k] = TAG_W'($urandom());

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 31;
        test_open_unlink();
        test_count_ceiling();
        test_index_range();
        test_wait_ring();

        idle_pct = 31;
        test_random(RANDOM_ITEMS);
        idle_pct = 57;
        test_random(RANDOM_ITEMS);
        idle_pct = 0;
        test_random(RANDOM_ITEMS);

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (longest scans under longest idles).
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cst_pkg.sv
rtl/cst_slot_store.sv
rtl/counting_semaphore_table.sv
verif/tb_top.sv
